// File: rtl/qfx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qfx_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int WORD_BITS     = 32;
    localparam int DIV_BITS      = WORD_BITS + FRACTION_BITS;
    localparam int DIV_STAGES    = DIV_BITS + 1;
    localparam logic [WORD_BITS-1:0] UNIT = WORD_BITS'(1) << FRACTION_BITS;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_MIN      = 4'd4,
        OP_MAX      = 4'd5,
        OP_INC      = 4'd6,
        OP_DEC      = 4'd7,
        OP_TO_INT   = 4'd8,
        OP_FROM_INT = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        KIND_SIMPLE,
        KIND_MUL,
        KIND_DIV
    } kind_t;

    typedef struct packed {
        kind_t                        kind;
        logic signed [WORD_BITS-1:0]  a;
        logic signed [WORD_BITS-1:0]  b;
        logic [WORD_BITS-1:0]         word;
        logic [WORD_BITS-1:0]         mag_a;
        logic [WORD_BITS-1:0]         mag_b;
        logic                         neg;
        logic                         lt;
        logic                         eq;
        logic                         gt;
        logic                         dz;
    } item_t;

endpackage
`default_nettype wire

// File: rtl/qfx_front.sv
`timescale 1ns / 1ps
`default_nettype none
module qfx_front
    import qfx_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [3:0]                  s_op,
    input  wire logic signed [WORD_BITS-1:0] s_a_raw,
    input  wire logic signed [WORD_BITS-1:0] s_b_raw,
    output logic                             f_valid,
    input  wire logic                        f_ready,
    output item_t                            f_item
);

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;

    assign s_ready = !valid_reg || f_ready;
    assign f_valid = valid_reg;
    assign f_item  = item_reg;

    always_comb begin
        item_next       = '0;
        item_next.a     = s_a_raw;
        item_next.b     = s_b_raw;
        item_next.lt    = s_a_raw < s_b_raw;
        item_next.eq    = s_a_raw == s_b_raw;
        item_next.gt    = s_a_raw > s_b_raw;
        item_next.mag_a = s_a_raw[WORD_BITS-1] ? -s_a_raw : s_a_raw;
        item_next.mag_b = s_b_raw[WORD_BITS-1] ? -s_b_raw : s_b_raw;
        item_next.neg   = s_a_raw[WORD_BITS-1] ^ s_b_raw[WORD_BITS-1];
        item_next.kind  = KIND_SIMPLE;
        case (s_op)
            OP_ADD:      item_next.word = s_a_raw + s_b_raw;
            OP_SUB:      item_next.word = s_a_raw - s_b_raw;
            OP_MUL:      item_next.kind = KIND_MUL;
            OP_DIV: begin
                if (s_b_raw == '0) begin
                    item_next.dz = 1'b1;
                end else begin
                    item_next.kind = KIND_DIV;
                end
            end
            OP_MIN:      item_next.word = (s_a_raw < s_b_raw) ? s_a_raw : s_b_raw;
            OP_MAX:      item_next.word = (s_a_raw > s_b_raw) ? s_a_raw : s_b_raw;
            OP_INC:      item_next.word = s_a_raw + UNIT;
            OP_DEC:      item_next.word = s_a_raw - UNIT;
            OP_TO_INT:   item_next.word = s_a_raw >>> FRACTION_BITS;
            OP_FROM_INT: item_next.word = s_a_raw << FRACTION_BITS;
            default:     item_next.word = '0;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/qfx_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module qfx_fifo
    import qfx_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    output logic       out_valid,
    input  wire logic  out_ready,
    output item_t      out_item
);

    item_t      mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

// File: rtl/qfx_back.sv
`timescale 1ns / 1ps
`default_nettype none
module qfx_back
    import qfx_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  b_valid,
    output logic                       b_ready,
    input  wire item_t                 b_item,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [WORD_BITS-1:0] m_result_raw,
    output logic                       m_less,
    output logic                       m_equal,
    output logic                       m_greater,
    output logic                       m_divide_by_zero
);

    logic                  st_valid_reg [DIV_STAGES];
    item_t                 st_item_reg  [DIV_STAGES];
    logic [WORD_BITS-1:0]  st_rem_reg   [DIV_STAGES];
    logic [DIV_BITS-1:0]   st_dvd_reg   [DIV_STAGES];
    item_t                 st_item_next [DIV_STAGES];
    logic [WORD_BITS-1:0]  st_rem_next  [DIV_STAGES];
    logic [DIV_BITS-1:0]   st_dvd_next  [DIV_STAGES];
    logic signed [2*WORD_BITS-1:0] prod_reg, prod_next;

    logic                 o_valid_reg;
    logic [WORD_BITS-1:0] o_result_reg, o_result_next;
    logic                 o_lt_reg, o_eq_reg, o_gt_reg, o_dz_reg;
    logic                 adv;
    item_t                last;
    logic [WORD_BITS-1:0] quo;

    assign adv     = !o_valid_reg || m_ready;
    assign b_ready = adv;

    assign m_valid          = o_valid_reg;
    assign m_result_raw     = o_result_reg;
    assign m_less           = o_lt_reg;
    assign m_equal          = o_eq_reg;
    assign m_greater        = o_gt_reg;
    assign m_divide_by_zero = o_dz_reg;

    always_comb begin
        logic [WORD_BITS:0] rem_w;
        logic               ge;
        prod_next      = (2*WORD_BITS)'(b_item.a) * (2*WORD_BITS)'(b_item.b);
        st_item_next[0] = b_item;
        st_rem_next[0]  = '0;
        st_dvd_next[0]  = {b_item.mag_a, {FRACTION_BITS{1'b0}}};
        for (int i = 0; i < DIV_STAGES - 1; i++) begin
            rem_w = {st_rem_reg[i], st_dvd_reg[i][DIV_BITS-1]};
            ge    = rem_w >= {1'b0, st_item_reg[i].mag_b};
            st_rem_next[i+1]  = ge ? WORD_BITS'(rem_w - {1'b0, st_item_reg[i].mag_b})
                                   : rem_w[WORD_BITS-1:0];
            st_dvd_next[i+1]  = {st_dvd_reg[i][DIV_BITS-2:0], ge};
            st_item_next[i+1] = st_item_reg[i];
            // product shift lands in the word on the way out of stage 0
            if (i == 0 && st_item_reg[0].kind == KIND_MUL) begin
                st_item_next[1].word = prod_reg[FRACTION_BITS +: WORD_BITS];
            end
        end
    end

    assign last = st_item_reg[DIV_STAGES-1];
    assign quo  = st_dvd_reg[DIV_STAGES-1][WORD_BITS-1:0];

    always_comb begin
        o_result_next = last.word;
        if (last.kind == KIND_DIV) begin
            o_result_next = last.neg ? -quo : quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                st_valid_reg[i] <= 1'b0;
            end
            o_valid_reg <= 1'b0;
        end else if (adv) begin
            st_valid_reg[0] <= b_valid;
            for (int i = 1; i < DIV_STAGES; i++) begin
                st_valid_reg[i] <= st_valid_reg[i-1];
            end
            o_valid_reg <= st_valid_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
            for (int i = 0; i < DIV_STAGES; i++) begin
                st_item_reg[i] <= st_item_next[i];
                st_rem_reg[i]  <= st_rem_next[i];
                st_dvd_reg[i]  <= st_dvd_next[i];
            end
            o_result_reg <= o_result_next;
            o_lt_reg     <= last.lt;
            o_eq_reg     <= last.eq;
            o_gt_reg     <= last.gt;
            o_dz_reg     <= last.dz;
        end
    end

endmodule
`default_nettype wire

// File: rtl/q24_8_fixed_point_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// path from input transfer to result valid: the front register loads at the transfer, then
// queue write, 41-stage back pipe with a quotient bit per stage past the first, output register
// throughput: one item per cycle unless m_ready stalls; all ops share the back pipe's fixed length
// reset: synchronous active-low aresetn clears all valid bits, queue pointers and queue count
module q24_8_fixed_point_alu
    import qfx_pkg::*;
(
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [3:0]                   s_op,
    input  wire logic signed [WORD_BITS-1:0]  s_a_raw,
    input  wire logic signed [WORD_BITS-1:0]  s_b_raw,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [WORD_BITS-1:0]       m_result_raw,
    output logic                              m_less,
    output logic                              m_equal,
    output logic                              m_greater,
    output logic                              m_divide_by_zero
);

    // front to queue
    logic  f_valid, f_ready;
    item_t f_item;
    // queue to back
    logic  b_valid, b_ready;
    item_t b_item;

    // front: decode, compare flags, simple ops, operand magnitudes
    qfx_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .s_a_raw (s_a_raw),
        .s_b_raw (s_b_raw),
        .f_valid (f_valid),
        .f_ready (f_ready),
        .f_item  (f_item)
    );

    // short queue decouples front stalls from back stalls
    qfx_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_item  (b_item)
    );

    // back: multiplier and pipelined restoring divider, then output register
    qfx_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .b_valid          (b_valid),
        .b_ready          (b_ready),
        .b_item           (b_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_raw     (m_result_raw),
        .m_less           (m_less),
        .m_equal          (m_equal),
        .m_greater        (m_greater),
        .m_divide_by_zero (m_divide_by_zero)
    );

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import qfx_pkg::*;

    // one expected result per accepted operation
    typedef struct {
        logic [31:0] result;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        dz;
    } alu_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [3:0]  s_op;
    logic signed [31:0] s_a_raw;
    logic signed [31:0] s_b_raw;
    logic        m_valid;
    logic        m_ready;
    logic signed [31:0] m_result_raw;
    logic        m_less;
    logic        m_equal;
    logic        m_greater;
    logic        m_divide_by_zero;

    alu_result_t expected_results[$];
    int          error_count;
    int          sent_count;
    int          result_count;
    int          src_idle_pct;
    int          snk_idle_pct;
    int          hold_off_cycles;
    int          quiet_cycles;
    int          op_seen[16];

    localparam int WATCHDOG_LIMIT = 5000;

    q24_8_fixed_point_alu u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_a_raw          (s_a_raw),
        .s_b_raw          (s_b_raw),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_raw     (m_result_raw),
        .m_less           (m_less),
        .m_equal          (m_equal),
        .m_greater        (m_greater),
        .m_divide_by_zero (m_divide_by_zero)
    );

    // free-running clock, 12 ns period
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // golden alu: computes result word and flags for one operation
    function automatic alu_result_t compute_alu(logic [3:0] op, logic signed [31:0] a,
                                                logic signed [31:0] b);
        alu_result_t        r;
        logic signed [63:0] prod;
        logic [63:0]        mag_a;
        logic [63:0]        mag_b;
        logic [63:0]        quot;
        r.dz = 1'b0;
        r.lt = (a < b);
        r.eq = (a == b);
        r.gt = (a > b);
        case (op)
            OP_ADD:      r.result = a + b;
            OP_SUB:      r.result = a - b;
            OP_MUL: begin
                prod = 64'(a) * 64'(b);
                prod = prod >>> FRACTION_BITS;
                r.result = prod[31:0];
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.result = '0;
                    r.dz = 1'b1;
                end else begin
                    mag_a = a[31] ? -64'(a) : 64'(a);
                    mag_b = b[31] ? -64'(b) : 64'(b);
                    quot = (mag_a << FRACTION_BITS) / mag_b;
                    if (a[31] != b[31]) quot = -quot;
                    r.result = quot[31:0];
                end
            end
            OP_MIN:      r.result = (a < b) ? a : b;
            OP_MAX:      r.result = (a > b) ? a : b;
            OP_INC:      r.result = a + UNIT;
            OP_DEC:      r.result = a - UNIT;
            OP_TO_INT:   r.result = a >>> FRACTION_BITS;
            OP_FROM_INT: r.result = a << FRACTION_BITS;
            default:     r.result = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on result %0d: %s got %h expected %h", result_count, what, got,
                 want);
        error_count++;
    endtask

    // offer one operation, holding it until the transfer
    task automatic send_op(logic [3:0] op, logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_a_raw <= a;
        s_b_raw <= b;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(compute_alu(op, a, b));
        op_seen[op]++;
        sent_count++;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7fff_ffff - $urandom_range(3);
            2: return $urandom_range(1023) - 512;
            3: return 32'({$urandom_range(255), 8'h00}) - 32'h8000;
            default: return $urandom;
        endcase
    endfunction

    // receiver side: random ready, optional long hold-off
    always @(negedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // result checker, compares each transfer with the oldest expectation
    always @(posedge aclk) begin
        alu_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("unexpected result %h", m_result_raw);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_result_raw !== want.result)
                    report_mismatch("result_raw", m_result_raw, want.result);
                if (m_less !== want.lt) report_mismatch("less", m_less, want.lt);
                if (m_equal !== want.eq) report_mismatch("equal", m_equal, want.eq);
                if (m_greater !== want.gt) report_mismatch("greater", m_greater, want.gt);
                if (m_divide_by_zero !== want.dz)
                    report_mismatch("divide_by_zero", m_divide_by_zero, want.dz);
            end
            result_count++;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // corner operands through every opcode, unused opcodes included
    task automatic test_directed();
        logic [3:0] op;
        send_op(OP_ADD, 32'h7fff_ffff, 32'h0000_0001);
        send_op(OP_SUB, 32'h8000_0000, 32'h0000_0001);
        send_op(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
        send_op(OP_MUL, 32'h8000_0000, 32'hffff_ff00);
        send_op(OP_MUL, 32'hffff_ffff, 32'h0000_0001);
        send_op(OP_DIV, 32'h0000_0500, 32'h0000_0000);
        send_op(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_op(OP_DIV, 32'hffff_fd00, 32'h0000_0200);
        send_op(OP_DIV, 32'h7fff_ffff, 32'h0000_0001);
        send_op(OP_MIN, 32'h1234_5678, 32'h1234_5678);
        send_op(OP_MAX, 32'h8000_0000, 32'h7fff_ffff);
        send_op(OP_MIN, 32'h8000_0000, 32'h7fff_ffff);
        send_op(OP_INC, 32'h7fff_ffff, 32'h0000_0000);
        send_op(OP_DEC, 32'h8000_0000, 32'hffff_ffff);
        send_op(OP_TO_INT, 32'hffff_ff01, 32'h0);
        send_op(OP_TO_INT, 32'h7fff_ffff, 32'h0);
        send_op(OP_FROM_INT, 32'h00ff_ffff, 32'h0);
        send_op(OP_FROM_INT, 32'hff80_0000, 32'h0);
        for (int i = 10; i < 16; i++) begin
            op = 4'(i);
            send_op(op, $urandom, $urandom);
        end
    endtask

    task automatic test_random(int count);
        logic [31:0] a;
        logic [3:0]  op;
        for (int i = 0; i < count; i++) begin
            a  = rand_operand();
            op = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
            case ($urandom_range(9))
                0: send_op(op, a, a);
                1: send_op(OP_DIV, a, 32'h0);
                default: send_op(op, a, rand_operand());
            endcase
        end
    endtask

    // receiver stalls long enough for the pipe to fill and push back
    task automatic test_backpressure();
        hold_off_cycles = 150;
        test_random(120);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op    = '0;
        s_a_raw = '0;
        s_b_raw = '0;
        m_ready = 1'b0;
        error_count = 0;
        sent_count = 0;
        result_count = 0;
        quiet_cycles = 0;
        hold_off_cycles = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        // sender idles 20 of 100, receiver 62
        src_idle_pct = 20;
        snk_idle_pct = 62;
        test_random(450);
        // roles swapped
        src_idle_pct = 62;
        snk_idle_pct = 20;
        test_random(450);
        // full rate both sides
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random(400);
        test_backpressure();
        drain();

        $display("sent %0d operations, checked %0d results, %0d divides and %0d multiplies",
                 sent_count, result_count, op_seen[OP_DIV], op_seen[OP_MUL]);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", error_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
